[sv/loss_hole_list_builder_assert.svh]
// Assertion macros used by the checker file
`ifndef LOSS_HOLE_LIST_BUILDER_ASSERT_SVH
`define LOSS_HOLE_LIST_BUILDER_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define LHB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define LHB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/lhb_pkg.sv]
package lhb_pkg;

    // Window and hole limits
    localparam int WINDOW_SIZE = 256;
    localparam int MAX_HOLES   = 16;
    localparam int WIN_W       = $clog2(WINDOW_SIZE);

    // Field widths
    localparam int OP_W    = 2;
    localparam int SEQ_W   = 16;
    localparam int KEY_W   = 64;
    localparam int ROUND_W = 16;
    localparam int ALPHA_W = 8;
    localparam int AC_W    = 7;
    localparam int HC_W    = 6;
    localparam int DUR_W   = 16;
    localparam int LOSS_W  = 8;
    localparam int KIND_W  = 2;

    // Arithmetic constants
    localparam int LATEST_MUL = 5;
    localparam int ALPHA_CAP  = 100;
    localparam int LOSS_CAP   = 255;
    localparam int LOSS_KNEE  = 5;
    localparam int DUR_CAP    = 100;
    localparam int DUR_SHORT  = 10;

    // Input tdata layout
    localparam int IN_SEQ_LSB   = 0;
    localparam int IN_RCV_BIT   = IN_SEQ_LSB + SEQ_W;
    localparam int IN_KEY_LSB   = IN_RCV_BIT + 1;
    localparam int IN_ROUND_LSB = IN_KEY_LSB + KEY_W;
    localparam int IN_RBIT_BIT  = IN_ROUND_LSB + ROUND_W;
    localparam int IN_ALPHA_LSB = IN_RBIT_BIT + 1;
    localparam int IN_USED_W    = IN_ALPHA_LSB + ALPHA_W;
    localparam int IN_DATA_W    = ((IN_USED_W + 7) / 8) * 8;

    // Output tdata layout
    localparam int OUT_LEFT_LSB  = 0;
    localparam int OUT_RIGHT_LSB = OUT_LEFT_LSB + SEQ_W;
    localparam int OUT_HC_LSB    = OUT_RIGHT_LSB + SEQ_W;
    localparam int OUT_ROUND_LSB = OUT_HC_LSB + HC_W;
    localparam int OUT_KEY_LSB   = OUT_ROUND_LSB + ROUND_W;
    localparam int OUT_DUR_LSB   = OUT_KEY_LSB + KEY_W;
    localparam int OUT_REARM_BIT = OUT_DUR_LSB + DUR_W;
    localparam int OUT_REPL_BIT  = OUT_REARM_BIT + 1;
    localparam int OUT_USED_W    = OUT_REPL_BIT + 1;
    localparam int OUT_DATA_W    = ((OUT_USED_W + 7) / 8) * 8;

    // Command queue
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    typedef enum logic [OP_W-1:0] {
        OP_MARK  = 2'd0,
        OP_REQ   = 2'd1,
        OP_TIMER = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [KIND_W-1:0] {
        KIND_HOLE    = 2'd0,
        KIND_SUMMARY = 2'd1,
        KIND_SEND    = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        CMD_MARK,
        CMD_REQ,
        CMD_TIMER
    } t_cmd_kind;

    typedef enum logic [1:0] {
        B_IDLE,
        B_SCAN,
        B_SUM
    } t_bstate;

    // Classified request as queued between front and back
    typedef struct packed {
        t_cmd_kind          kind;
        logic [WIN_W-1:0]   widx;
        logic               mark;
        logic [KEY_W-1:0]   key;
        logic [ROUND_W-1:0] round;
        logic               rbit;
        logic [AC_W-1:0]    alpha;
        logic [SEQ_W-1:0]   latest;
        logic [SEQ_W-1:0]   start;
    } t_cmd;

    // Queue head as seen by the back end
    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_q_head;

endpackage

[sv/lhb_front.sv]
module lhb_front (
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [lhb_pkg::IN_DATA_W-1:0] i_s_tdata,
    input  logic [lhb_pkg::OP_W-1:0]      i_s_tuser,
    input  logic                          i_q_full,
    output logic                          o_push,
    output lhb_pkg::t_cmd                 o_cmd
);
    import lhb_pkg::*;

    t_op                op;
    logic [ROUND_W-1:0] round;
    logic [ALPHA_W-1:0] alpha;
    logic [SEQ_W-1:0]   latest;

    // Accept whenever the queue has room; drop unused op codes
    assign o_s_tready = !i_q_full;
    assign op         = t_op'(i_s_tuser);
    assign o_push     = i_s_tvalid && o_s_tready && (op != OP_NONE);

    assign round = i_s_tdata[IN_ROUND_LSB +: ROUND_W];
    assign alpha = i_s_tdata[IN_ALPHA_LSB +: ALPHA_W];

    // Latest index is five times the round, modulo 2^16
    assign latest = SEQ_W'({round, 2'b00}) + round;

    // Classify and precompute the scan range
    always_comb begin
        case (op)
            OP_MARK:  o_cmd.kind = CMD_MARK;
            OP_REQ:   o_cmd.kind = CMD_REQ;
            default:  o_cmd.kind = CMD_TIMER;
        endcase
        o_cmd.widx   = i_s_tdata[IN_SEQ_LSB +: WIN_W];
        o_cmd.mark   = i_s_tdata[IN_RCV_BIT];
        o_cmd.key    = i_s_tdata[IN_KEY_LSB +: KEY_W];
        o_cmd.round  = round;
        o_cmd.rbit   = i_s_tdata[IN_RBIT_BIT];
        o_cmd.alpha  = (alpha > ALPHA_W'(ALPHA_CAP)) ? AC_W'(ALPHA_CAP) : alpha[AC_W-1:0];
        o_cmd.latest = latest;
        o_cmd.start  = (latest >= SEQ_W'(WINDOW_SIZE)) ? latest - SEQ_W'(WINDOW_SIZE)
                                                       : '0;
    end

endmodule

[sv/lhb_queue.sv]
module lhb_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  lhb_pkg::t_cmd    i_cmd,
    output logic             o_full,
    input  logic             i_pop,
    output lhb_pkg::t_q_head o_head
);
    import lhb_pkg::*;

    t_cmd            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wp;
    logic [Q_AW-1:0] r_rp;
    logic [Q_CW-1:0] r_cnt;

    assign o_full       = (r_cnt == Q_CW'(Q_DEPTH));
    assign o_head.valid = (r_cnt != '0);
    assign o_head.cmd   = r_mem[r_rp];

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

endmodule

[sv/lhb_back.sv]
module lhb_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  lhb_pkg::t_q_head               i_head,
    output logic                           o_pop,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [lhb_pkg::OUT_DATA_W-1:0] o_m_tdata,
    output logic [lhb_pkg::KIND_W-1:0]     o_m_tuser,
    output logic                           o_m_tlast
);
    import lhb_pkg::*;

    localparam int TERM_W = LOSS_W + 1;
    localparam int PROD_W = AC_W + TERM_W;

    function automatic logic [OUT_DATA_W-1:0] pack_out(
        input logic [SEQ_W-1:0]   left,
        input logic [SEQ_W-1:0]   right,
        input logic [HC_W-1:0]    count,
        input logic [ROUND_W-1:0] rnd,
        input logic [KEY_W-1:0]   key,
        input logic [DUR_W-1:0]   dur,
        input logic               rearm,
        input logic               repl
    );
        logic [OUT_DATA_W-1:0] v;
        v = '0;
        v[OUT_LEFT_LSB +: SEQ_W]    = left;
        v[OUT_RIGHT_LSB +: SEQ_W]   = right;
        v[OUT_HC_LSB +: HC_W]       = count;
        v[OUT_ROUND_LSB +: ROUND_W] = rnd;
        v[OUT_KEY_LSB +: KEY_W]     = key;
        v[OUT_DUR_LSB +: DUR_W]     = dur;
        v[OUT_REARM_BIT]            = rearm;
        v[OUT_REPL_BIT]             = repl;
        return v;
    endfunction

    t_bstate r_state, n_state;

    // Receive map: memory plus per-entry valid bits
    logic                   r_map_mem [WINDOW_SIZE];
    logic [WINDOW_SIZE-1:0] r_map_vld;

    // Pending request
    logic               r_pending;
    logic [ROUND_W-1:0] r_pend_round;

    // Latched request
    logic [KEY_W-1:0]   r_key;
    logic [ROUND_W-1:0] r_round;
    logic               r_rbit;
    logic [AC_W-1:0]    r_alpha;
    logic [SEQ_W-1:0]   r_latest;

    // Scan pipeline
    logic [SEQ_W-1:0]  r_idx;
    logic              r_issue;
    logic              r_rd_vld;
    logic              r_rd_mbit;
    logic              r_rd_vbit;
    logic [SEQ_W-1:0]  r_rd_idx;
    logic              r_rd_end;
    logic              r_in_hole;
    logic [SEQ_W-1:0]  r_left;
    logic [HC_W-1:0]   r_holes;
    logic [LOSS_W-1:0] r_loss;

    // Output register
    logic                  r_out_valid;
    t_kind                 r_out_kind;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic                  r_out_last;

    // Control from the output block
    logic can_emit;
    logic do_mark, do_start, do_send, rd_en, adv;
    logic hole_close, scan_done, sum_emit, load;

    logic              rd_bit;
    logic [SEQ_W-1:0]  hole_left_v, hole_right_v, hole_len;
    logic [SEQ_W:0]    loss_sum;
    logic [LOSS_W-1:0] n_loss;
    logic [LOSS_W-1:0] term;
    logic [TERM_W-1:0] term1;
    logic [PROD_W-1:0] prod;
    logic [PROD_W:0]   dur_raw;
    logic [DUR_W-1:0]  dur_rearm;

    assign can_emit = !r_out_valid || i_m_tready;
    assign rd_bit   = r_rd_mbit & r_rd_vbit;

    // Hole bounds and running loss
    assign hole_left_v  = (rd_bit || r_in_hole) ? r_left : r_rd_idx;
    assign hole_right_v = rd_bit ? r_rd_idx - 1'b1 : r_rd_idx;
    assign hole_len     = hole_right_v - hole_left_v + 1'b1;
    assign loss_sum     = (SEQ_W+1)'(r_loss) + (SEQ_W+1)'(hole_len);
    assign n_loss       = (loss_sum > (SEQ_W+1)'(LOSS_CAP)) ? LOSS_W'(LOSS_CAP)
                                                            : loss_sum[LOSS_W-1:0];

    // Backoff duration from the saturated loss count
    assign term      = (r_loss <= LOSS_W'(LOSS_KNEE)) ? LOSS_W'(LOSS_KNEE) - r_loss : r_loss;
    assign term1     = TERM_W'(term) + TERM_W'(r_rbit);
    assign prod      = PROD_W'(r_alpha) * PROD_W'(term1);
    assign dur_raw   = {prod, 1'b0};
    assign dur_rearm = (dur_raw == '0)                   ? DUR_W'(1) :
                       (dur_raw > (PROD_W+1)'(DUR_CAP)) ? DUR_W'(DUR_SHORT) :
                                                          dur_raw[DUR_W-1:0];

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE: begin
                if (do_start) begin
                    n_state = (i_head.cmd.latest == '0) ? B_SUM : B_SCAN;
                end
            end
            B_SCAN: begin
                if (scan_done) begin
                    n_state = B_SUM;
                end
            end
            B_SUM: begin
                if (sum_emit) begin
                    n_state = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    // Control outputs
    always_comb begin
        o_pop      = 1'b0;
        do_mark    = 1'b0;
        do_start   = 1'b0;
        do_send    = 1'b0;
        adv        = 1'b0;
        rd_en      = 1'b0;
        hole_close = 1'b0;
        scan_done  = 1'b0;
        sum_emit   = 1'b0;
        case (r_state)
            B_IDLE: begin
                if (i_head.valid) begin
                    case (i_head.cmd.kind)
                        CMD_MARK: begin
                            o_pop   = 1'b1;
                            do_mark = 1'b1;
                        end
                        CMD_REQ: begin
                            o_pop    = 1'b1;
                            do_start = 1'b1;
                        end
                        default: begin
                            o_pop   = !r_pending || can_emit;
                            do_send = r_pending && can_emit;
                        end
                    endcase
                end
            end
            B_SCAN: begin
                adv        = can_emit;
                rd_en      = can_emit && r_issue;
                hole_close = can_emit && r_rd_vld && (rd_bit ? r_in_hole : r_rd_end);
                scan_done  = can_emit && r_rd_vld &&
                             (r_rd_end || (hole_close && (r_holes == HC_W'(MAX_HOLES - 1))));
            end
            B_SUM: begin
                sum_emit = can_emit;
            end
            default: ;
        endcase
    end

    assign load = do_send || hole_close || sum_emit;

    // State, pending and scan control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= B_IDLE;
            r_pending    <= 1'b0;
            r_pend_round <= '0;
            r_map_vld    <= '0;
            r_issue      <= 1'b0;
            r_rd_vld     <= 1'b0;
            r_in_hole    <= 1'b0;
            r_holes      <= '0;
            r_loss       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (do_mark) begin
                r_map_vld[i_head.cmd.widx] <= 1'b1;
            end
            if (do_send) begin
                r_pending <= 1'b0;
            end else if (sum_emit) begin
                r_pending    <= 1'b1;
                r_pend_round <= r_round;
            end
            if (do_start) begin
                r_issue   <= (i_head.cmd.latest != '0);
                r_rd_vld  <= 1'b0;
                r_in_hole <= 1'b0;
                r_holes   <= '0;
                r_loss    <= '0;
            end else if (adv) begin
                if (scan_done) begin
                    r_issue  <= 1'b0;
                    r_rd_vld <= 1'b0;
                end else begin
                    r_rd_vld <= r_issue;
                    if (r_issue) begin
                        r_issue <= (r_idx != r_latest - 1'b1);
                    end
                end
                if (r_rd_vld) begin
                    r_in_hole <= !rd_bit;
                end
                if (hole_close) begin
                    r_holes <= r_holes + 1'b1;
                    r_loss  <= n_loss;
                end
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Receive map write and registered read
    always_ff @(posedge i_clk) begin
        if (do_mark) begin
            r_map_mem[i_head.cmd.widx] <= i_head.cmd.mark;
        end
        if (rd_en) begin
            r_rd_mbit <= r_map_mem[r_idx[WIN_W-1:0]];
            r_rd_vbit <= r_map_vld[r_idx[WIN_W-1:0]];
        end
    end

    // Request latch, scan indices and hole start
    always_ff @(posedge i_clk) begin
        if (do_start) begin
            r_key    <= i_head.cmd.key;
            r_round  <= i_head.cmd.round;
            r_rbit   <= i_head.cmd.rbit;
            r_alpha  <= i_head.cmd.alpha;
            r_latest <= i_head.cmd.latest;
            r_idx    <= i_head.cmd.start;
        end else if (rd_en) begin
            r_rd_idx <= r_idx;
            r_rd_end <= (r_idx == r_latest - 1'b1);
            r_idx    <= r_idx + 1'b1;
        end
        if (adv && r_rd_vld && !rd_bit && !r_in_hole) begin
            r_left <= r_rd_idx;
        end
    end

    // Load the output register
    always_ff @(posedge i_clk) begin
        if (do_send) begin
            r_out_kind <= KIND_SEND;
            r_out_last <= 1'b1;
            r_out_data <= pack_out('0, '0, '0, r_pend_round, '0, '0, 1'b0, 1'b0);
        end else if (hole_close) begin
            r_out_kind <= KIND_HOLE;
            r_out_last <= 1'b0;
            r_out_data <= pack_out(hole_left_v, hole_right_v, '0, '0, '0, '0, 1'b0, 1'b0);
        end else if (sum_emit) begin
            r_out_kind <= KIND_SUMMARY;
            r_out_last <= 1'b1;
            r_out_data <= pack_out('0, '0, r_holes, r_round, r_key,
                                   r_pending ? '0 : dur_rearm, !r_pending, r_pending);
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_kind;
    assign o_m_tlast  = r_out_last;

endmodule

[sv/loss_hole_list_builder.sv]
// Channel   | Dir | Handshake            | Payload
// ----------+-----+----------------------+---------------------------------------------
// request   | in  | i_s_tvalid/o_s_tready| tuser op; tdata seq..alpha
// result    | out | o_m_tvalid/i_m_tready| tuser kind; tdata hole..flags; tlast last
//
// A mark write or timer request is handled in the back end from the queue head.
// A DACK request scans up to min(latest, WINDOW_SIZE) indices: the back end reads the
// receive map one index per unstalled cycle via its single registered read port.
// Reset clears the receive map valid bits, the pending flag and the queue.
// A stalled result halts the scan in place; the two-entry queue takes requests until full.
module loss_hole_list_builder (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // tdata: seq[15:0], received[16], stream_key[80:17], round[96:81],
    //        random_bit[97], alpha[105:98], zero pad
    input  logic [lhb_pkg::IN_DATA_W-1:0]  i_s_tdata,
    // tuser: op[1:0]
    input  logic [lhb_pkg::OP_W-1:0]       i_s_tuser,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // tdata: hole_left[15:0], hole_right[31:16], hole_count[37:32], round_out[53:38],
    //        key_out[117:54], duration[133:118], rearm_timer[134],
    //        replaced_pending[135], zero pad
    output logic [lhb_pkg::OUT_DATA_W-1:0] o_m_tdata,
    // tuser: kind[1:0]
    output logic [lhb_pkg::KIND_W-1:0]     o_m_tuser,
    output logic                           o_m_tlast
);
    import lhb_pkg::*;

    logic    q_full;
    logic    q_push;
    logic    q_pop;
    t_cmd    q_cmd;
    t_q_head q_head;

    lhb_front u_front (
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_q_full   (q_full),
        .o_push     (q_push),
        .o_cmd      (q_cmd)
    );

    lhb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_head  (q_head)
    );

    lhb_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (q_head),
        .o_pop      (q_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

[sv/lhb_checker.sv]
`include "loss_hole_list_builder_assert.svh"

module lhb_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_m_tvalid,
    input logic                           i_m_tready,
    input logic [lhb_pkg::OUT_DATA_W-1:0] o_m_tdata,
    input logic [lhb_pkg::KIND_W-1:0]     o_m_tuser,
    input logic                           o_m_tlast
);
    import lhb_pkg::*;

    logic                 is_hole;
    logic                 is_sum;
    logic [DUR_W-1:0]     dur;

    assign is_hole = o_m_tvalid && (o_m_tuser == KIND_HOLE);
    assign is_sum  = o_m_tvalid && (o_m_tuser == KIND_SUMMARY);
    assign dur     = o_m_tdata[OUT_DUR_LSB +: DUR_W];

    // Hold a stalled result
    `LHB_ASSERT_NEXT(a_out_hold, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser) && $stable(o_m_tlast), "result changed while stalled")

    // Only summaries and sends close a request
    `LHB_ASSERT_NOW(a_last_kind, o_m_tvalid, o_m_tlast == !is_hole, "tlast does not match result kind")

    // A summary either rearms the timer or replaces a pending request
    `LHB_ASSERT_NOW(a_sum_flags, is_sum, o_m_tdata[OUT_REARM_BIT] != o_m_tdata[OUT_REPL_BIT], "summary flags not exclusive")

    // A rearmed timer gets a short nonzero backoff; a replacement carries none
    `LHB_ASSERT_NOW(a_sum_dur, is_sum, o_m_tdata[OUT_REARM_BIT] ? (dur != '0 && dur <= DUR_W'(DUR_CAP)) : (dur == '0), "summary duration out of range")

    // Summary never counts more holes than allowed
    `LHB_ASSERT_NOW(a_sum_count, is_sum, o_m_tdata[OUT_HC_LSB +: HC_W] <= HC_W'(MAX_HOLES), "hole count above limit")

endmodule

bind loss_hole_list_builder lhb_checker u_lhb_checker (.*);
